### design/rkos_pkg.sv
`timescale 1ns / 1ps
package rkos_pkg;

  localparam int RKOS_WORD_BITS  = 32;
  localparam int RKOS_FRAC_BITS  = 16;
  localparam int RKOS_COUNT_BITS = 16;

  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_INDEX_BITS = 3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_START_X    = 3'd0,
    CFG_START_Y    = 3'd1,
    CFG_STEP_SIZE  = 3'd2,
    CFG_STEP_COUNT = 3'd3,
    CFG_ORDER      = 3'd4
  } rkos_cfg_e;

  localparam logic [31:0] START_X_RST    = 32'd0;
  localparam logic [31:0] START_Y_RST    = 32'd65536;
  localparam logic [31:0] STEP_SIZE_RST  = 32'd6554;
  localparam logic [15:0] STEP_COUNT_RST = 16'd10;
  localparam logic        ORDER_RST      = 1'b1;

  localparam logic ORDER_HEUN = 1'b0;
  localparam logic ORDER_RK4  = 1'b1;

  // divisor of the fourth order weighted sum
  localparam logic [3:0] SIXTH_DIV = 4'd6;
  // floor correction added to a negative magnitude before dividing by six
  localparam int SIXTH_BIAS = 5;

  // digit width of the shared multiplier
  localparam int MUL_DIGIT_BITS = 16;

  typedef struct packed {
    logic reload;
    logic last;
  } rkos_flags_t;

  typedef struct packed {
    logic start;
    logic neg;
    logic frac;
  } rkos_mul_ctl_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } rkos_mul_stat_t;

endpackage

### design/rkos_if.sv
`timescale 1ns / 1ps
interface rkos_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface rkos_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        step_index;
  logic signed [31:0] x_next;
  logic signed [31:0] y_next;
  logic signed [31:0] slope1;
  logic signed [31:0] slope2;
  logic signed [31:0] slope3;
  logic signed [31:0] slope4;
  logic               last;
  logic               overflow;

  modport source (output valid, output step_index, output x_next, output y_next,
                  output slope1, output slope2, output slope3, output slope4,
                  output last, output overflow, input ready);
  modport sink   (input valid, input step_index, input x_next, input y_next,
                  input slope1, input slope2, input slope3, input slope4,
                  input last, input overflow, output ready);
endinterface

### design/rkos_front.sv
`timescale 1ns / 1ps
module rkos_front #(
  parameter int COUNT_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  rkos_in_if.sink                item,
  input  logic [15:0]            step_count,
  output logic                   push_valid,
  input  logic                   push_ready,
  output rkos_pkg::rkos_flags_t  push_flags,
  output logic [COUNT_BITS-1:0]  push_index
);
  import rkos_pkg::*;

  localparam int EB = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam logic [COUNT_BITS-1:0] CNT_MASK = '1;

  logic [COUNT_BITS-1:0] counter;
  logic                  pending;
  logic                  reload;
  logic [COUNT_BITS-1:0] cur;
  logic [EB-1:0]         cnt_eff;
  logic                  is_last;
  logic                  accept;

  assign item.ready = push_ready;
  assign push_valid = item.valid;
  assign accept     = item.valid && push_ready;

  assign reload = item.restart || pending;
  assign cur    = reload ? COUNT_BITS'(1) : counter;

  // zero count acts as one, counts beyond the counter range clamp
  always_comb begin
    cnt_eff = EB'(step_count);
    if (cnt_eff == '0) begin
      cnt_eff = EB'(1);
    end else if (cnt_eff > EB'(CNT_MASK)) begin
      cnt_eff = EB'(CNT_MASK);
    end
  end

  assign is_last           = EB'(cur) >= cnt_eff;
  assign push_flags.reload = reload;
  assign push_flags.last   = is_last;
  assign push_index        = cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= COUNT_BITS'(1);
      pending <= 1'b1;
    end else if (accept) begin
      pending <= is_last;
      if (is_last) begin
        counter <= cur;
      end else begin
        counter <= cur + COUNT_BITS'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_last_reloads: assert property (@(posedge clk) disable iff (rst)
    (accept && is_last) |=> pending)
    else $error("run end did not arm a reload");
`endif

endmodule

### design/rkos_fifo.sv
`timescale 1ns / 1ps
module rkos_fifo #(
  parameter int DATA_BITS = 18
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_valid,
  output logic                 wr_ready,
  input  logic [DATA_BITS-1:0] wr_data,
  output logic                 rd_valid,
  input  logic                 rd_ready,
  output logic [DATA_BITS-1:0] rd_data
);

  logic [DATA_BITS-1:0] mem [2];
  logic                 wp;
  logic                 rp;
  logic [1:0]           count;
  logic                 do_wr;
  logic                 do_rd;

  assign wr_ready = count != 2'd2;
  assign rd_valid = count != 2'd0;
  assign rd_data  = mem[rp];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wp] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_wr) wp <= ~wp;
      if (do_rd) rp <= ~rp;
      count <= count + 2'(do_wr) - 2'(do_rd);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("queue count out of range");
`endif

endmodule

### design/rkos_mul.sv
`timescale 1ns / 1ps
module rkos_mul #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16,
  parameter int MAG_BITS  = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  rkos_pkg::rkos_mul_ctl_t      ctl,
  input  logic [MAG_BITS-1:0]          a_mag,
  input  logic [MAG_BITS-1:0]          b_mag,
  output rkos_pkg::rkos_mul_stat_t     stat,
  output logic signed [WORD_BITS-1:0]  res
);
  import rkos_pkg::*;

  localparam int DB  = MUL_DIGIT_BITS;
  localparam int ND  = (MAG_BITS + DB - 1) / DB;
  localparam int BP  = ND * DB;
  localparam int PW  = MAG_BITS + BP + 1;
  localparam int DCW = $clog2(ND + 1);
  localparam logic [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic [PW-1:0] RND = PW'((64'd1 << FRAC_BITS) - 64'd1);

  typedef enum logic [2:0] {
    M_IDLE = 3'b001,
    M_RUN  = 3'b010,
    M_FIN  = 3'b100
  } mstate_t;

  mstate_t               state;
  logic [MAG_BITS-1:0]   a_r;
  logic [BP-1:0]         b_r;
  logic                  neg_r;
  logic                  frac_r;
  logic [DCW-1:0]        dc;
  logic [PW-1:0]         acc;
  logic [MAG_BITS+DB-1:0] pp;
  logic [PW-1:0]         sum;
  logic [PW-1:0]         shifted;
  logic [PW-1:0]         limit;
  logic                  over;
  logic [WORD_BITS-1:0]  q;
  logic [WORD_BITS-1:0]  fin_res;

  // one digit of b per cycle, most significant first
  assign pp = a_r * b_r[BP-1 -: DB];

  always_comb begin
    sum     = acc + ((neg_r && frac_r) ? RND : '0);
    shifted = frac_r ? (sum >> FRAC_BITS) : sum;
    limit   = neg_r ? PW'(WMIN) : PW'(WMAX);
    over    = shifted > limit;
    q       = shifted[WORD_BITS-1:0];
    if (over) begin
      fin_res = neg_r ? WMIN : WMAX;
    end else begin
      fin_res = neg_r ? (~q + WORD_BITS'(1)) : q;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start && state == M_IDLE) begin
      a_r    <= a_mag;
      b_r    <= BP'(b_mag);
      neg_r  <= ctl.neg;
      frac_r <= ctl.frac;
      acc    <= '0;
    end else if (state == M_RUN) begin
      acc <= (acc << DB) + PW'(pp);
      b_r <= b_r << DB;
    end
    if (state == M_FIN) begin
      res <= signed'(fin_res);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= M_IDLE;
      dc        <= '0;
      stat.done <= 1'b0;
      stat.ovf  <= 1'b0;
    end else begin
      stat.done <= 1'b0;
      unique case (state)
        M_IDLE: begin
          if (ctl.start) begin
            dc    <= '0;
            state <= M_RUN;
          end
        end
        M_RUN: begin
          dc <= dc + DCW'(1);
          if (dc == DCW'(ND - 1)) state <= M_FIN;
        end
        M_FIN: begin
          stat.done <= 1'b1;
          stat.ovf  <= over;
          state     <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_after_fin: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> $past(state == M_FIN))
    else $error("multiplier done without a finishing cycle");
`endif

endmodule

### design/rkos_back.sv
`timescale 1ns / 1ps
module rkos_back #(
  parameter int WORD_BITS  = 32,
  parameter int COUNT_BITS = 16,
  parameter int MAG_BITS   = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic signed [WORD_BITS-1:0]  start_x,
  input  logic signed [WORD_BITS-1:0]  start_y,
  input  logic signed [WORD_BITS-1:0]  step_size,
  input  logic                         order,
  input  logic                         q_valid,
  output logic                         q_pop,
  input  rkos_pkg::rkos_flags_t        q_flags,
  input  logic [COUNT_BITS-1:0]        q_index,
  output rkos_pkg::rkos_mul_ctl_t      mctl,
  output logic [MAG_BITS-1:0]          m_a,
  output logic [MAG_BITS-1:0]          m_b,
  input  rkos_pkg::rkos_mul_stat_t     mstat,
  input  logic signed [WORD_BITS-1:0]  m_res,
  rkos_out_if.source                   result
);
  import rkos_pkg::*;

  localparam int W   = WORD_BITS;
  localparam int DB  = MUL_DIGIT_BITS;
  localparam int DND = (W + DB - 1) / DB;
  localparam int DBP = DND * DB;
  localparam int DCB = $clog2(DND + 1);
  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] ONES = '1;
  // ceil(2^W / 3), exact for a dividend below 2^(W-1)
  localparam logic [W-1:0] REC3 = ONES / W'(SIXTH_DIV >> 1) + W'(1);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_XW    = 13'b0000000000010,
    S_XE    = 13'b0000000000100,
    S_ARG   = 13'b0000000001000,
    S_M1    = 13'b0000000010000,
    S_M2    = 13'b0000000100000,
    S_SUB   = 13'b0000001000000,
    S_M3    = 13'b0000010000000,
    S_SUM   = 13'b0000100000000,
    S_DINIT = 13'b0001000000000,
    S_DIV   = 13'b0010000000000,
    S_UPD   = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } bstate_t;

  function automatic logic [W:0] sadd(logic signed [W-1:0] a, logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = $signed({a[W-1], a}) + $signed({b[W-1], b});
    if (s[W] != s[W-1]) return {1'b1, (s[W] ? WMIN : WMAX)};
    return {1'b0, s[W-1:0]};
  endfunction

  function automatic logic [W:0] ssub(logic signed [W-1:0] a, logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = $signed({a[W-1], a}) - $signed({b[W-1], b});
    if (s[W] != s[W-1]) return {1'b1, (s[W] ? WMIN : WMAX)};
    return {1'b0, s[W-1:0]};
  endfunction

  function automatic logic [MAG_BITS-1:0] mag(logic signed [W-1:0] v);
    logic [W:0] e;
    e = {v[W-1], v};
    if (v[W-1]) e = ~e + (W+1)'(1);
    return MAG_BITS'(e[W-1:0]);
  endfunction

  bstate_t state;
  logic [1:0] j;
  logic [2:0] sc;
  logic signed [W-1:0] y, h, x, xe, xh, xs, ys, t;
  logic signed [W-1:0] k1, k2, k3, k4, acc;
  logic [COUNT_BITS-1:0] idx;
  logic last_r;
  logic ovf;
  logic dneg;
  logic [W-1:0] dq;
  logic [DBP-1:0] drec;
  logic [W+DBP-1:0] dacc;
  logic [DCB-1:0] dcnt;

  logic [W:0] arg_sum, xw_sum, xe_sum, xh_sum, sub_res, sum_step, heun_sum, upd_sum;
  logic signed [W-1:0] arg_y, arg_x, sum_sel;
  logic [W:0] dmag;
  logic [W+DB-1:0] dpp;
  logic [W-1:0] dquo;
  logic last_slope;
  logic out_free;

  assign q_pop    = (state == S_IDLE) && q_valid;
  assign out_free = !result.valid || result.ready;

  always_comb begin
    arg_sum = {1'b0, y};
    arg_x   = x;
    unique case (j)
      2'd0: begin
        arg_sum = {1'b0, y};
        arg_x   = x;
      end
      2'd1: begin
        arg_sum = sadd(y, (order == ORDER_RK4) ? (k1 >>> 1) : k1);
        arg_x   = (order == ORDER_RK4) ? xh : xe;
      end
      2'd2: begin
        arg_sum = sadd(y, k2 >>> 1);
        arg_x   = xh;
      end
      2'd3: begin
        arg_sum = sadd(y, k3);
        arg_x   = xe;
      end
      default: ;
    endcase
    arg_y = signed'(arg_sum[W-1:0]);
  end

  always_comb begin
    unique case (sc)
      3'd0, 3'd1: sum_sel = k2;
      3'd2, 3'd3: sum_sel = k3;
      default:    sum_sel = k4;
    endcase
  end

  assign xw_sum   = sadd(start_x, m_res);
  assign xe_sum   = sadd(x, h);
  assign xh_sum   = sadd(x, h >>> 1);
  assign sub_res  = ssub(t, ys);
  assign sum_step = sadd(acc, sum_sel);
  assign heun_sum = sadd(k1, k2);
  assign upd_sum  = sadd(y, acc);
  assign last_slope = (order == ORDER_RK4) ? (j == 2'd3) : (j == 2'd1);

  // floor division by six on the magnitude, bias for negatives
  always_comb begin
    dmag = {acc[W-1], acc};
    if (acc[W-1]) dmag = ~dmag + (W+1)'(1);
    dmag = dmag + (W+1)'(acc[W-1] ? SIXTH_BIAS : 0);
  end

  // halved magnitude times the reciprocal of three, one digit per cycle
  assign dpp  = dq * drec[DBP-1 -: DB];
  assign dquo = dacc[W +: W];

  always_ff @(posedge clk) begin
    mctl.start <= 1'b0;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          idx    <= q_index;
          last_r <= q_flags.last;
          h      <= step_size;
          if (q_flags.reload) y <= start_y;
          m_a       <= mag(step_size);
          m_b       <= MAG_BITS'((q_index == '0) ? '0 : (q_index - COUNT_BITS'(1)));
          mctl.neg  <= step_size[W-1];
          mctl.frac <= 1'b0;
          mctl.start <= 1'b1;
        end
      end
      S_XW: if (mstat.done) x <= signed'(xw_sum[W-1:0]);
      S_XE: begin
        xe <= signed'(xe_sum[W-1:0]);
        xh <= signed'(xh_sum[W-1:0]);
        j  <= 2'd0;
      end
      S_ARG: begin
        xs <= arg_x;
        ys <= arg_y;
        m_a       <= mag(arg_y);
        m_b       <= mag(arg_x);
        mctl.neg  <= arg_y[W-1] ^ arg_x[W-1];
        mctl.frac <= 1'b1;
        mctl.start <= 1'b1;
      end
      S_M1: begin
        if (mstat.done) begin
          m_a       <= mag(m_res);
          m_b       <= mag(xs);
          mctl.neg  <= m_res[W-1] ^ xs[W-1];
          mctl.start <= 1'b1;
        end
      end
      S_M2: if (mstat.done) t <= m_res;
      S_SUB: begin
        m_a        <= mag(h);
        m_b        <= mag(signed'(sub_res[W-1:0]));
        mctl.neg   <= h[W-1] ^ sub_res[W-1];
        mctl.start <= 1'b1;
      end
      S_M3: begin
        if (mstat.done) begin
          unique case (j)
            2'd0: k1 <= m_res;
            2'd1: k2 <= m_res;
            2'd2: k3 <= m_res;
            2'd3: k4 <= m_res;
            default: ;
          endcase
          if (j == 2'd0) acc <= m_res;
          sc <= 3'd0;
          if (!last_slope) j <= j + 2'd1;
        end
      end
      S_SUM: begin
        if (order == ORDER_HEUN) begin
          acc <= signed'(heun_sum[W-1:0]) >>> 1;
        end else begin
          acc <= signed'(sum_step[W-1:0]);
          sc  <= sc + 3'd1;
        end
      end
      S_DINIT: begin
        dneg <= acc[W-1];
        dq   <= dmag[W:1];
        drec <= DBP'(REC3);
        dacc <= '0;
        dcnt <= '0;
      end
      S_DIV: begin
        if (dcnt == DCB'(DND)) begin
          acc <= dneg ? signed'(~dquo + W'(1)) : signed'(dquo);
        end else begin
          dacc <= (dacc << DB) + (W+DBP)'(dpp);
          drec <= drec << DB;
          dcnt <= dcnt + DCB'(1);
        end
      end
      S_UPD: y <= signed'(upd_sum[W-1:0]);
      default: ;
    endcase
  end

  // overflow flag of the step in flight
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE:  if (q_valid) ovf <= 1'b0;
      S_XW:    if (mstat.done) ovf <= ovf | mstat.ovf | xw_sum[W];
      S_XE:    ovf <= ovf | xe_sum[W] | ((order == ORDER_RK4) & xh_sum[W]);
      S_ARG:   ovf <= ovf | ((j != 2'd0) & arg_sum[W]);
      S_M1, S_M2, S_M3: if (mstat.done) ovf <= ovf | mstat.ovf;
      S_SUB:   ovf <= ovf | sub_res[W];
      S_SUM:   ovf <= ovf | ((order == ORDER_HEUN) ? heun_sum[W] : sum_step[W]);
      S_UPD:   ovf <= ovf | upd_sum[W];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:  if (q_valid) state <= S_XW;
        S_XW:    if (mstat.done) state <= S_XE;
        S_XE:    state <= S_ARG;
        S_ARG:   state <= S_M1;
        S_M1:    if (mstat.done) state <= S_M2;
        S_M2:    if (mstat.done) state <= S_SUB;
        S_SUB:   state <= S_M3;
        S_M3: begin
          if (mstat.done) state <= last_slope ? S_SUM : S_ARG;
        end
        S_SUM: begin
          if (order == ORDER_HEUN) state <= S_UPD;
          else if (sc == 3'd4) state <= S_DINIT;
        end
        S_DINIT: state <= S_DIV;
        S_DIV:   if (dcnt == DCB'(DND)) state <= S_UPD;
        S_UPD:   state <= S_OUT;
        S_OUT:   if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      result.step_index <= 16'(idx);
      result.x_next     <= 32'(xe);
      result.y_next     <= 32'(y);
      result.slope1     <= 32'(k1);
      result.slope2     <= 32'(k2);
      result.slope3     <= (order == ORDER_RK4) ? 32'(k3) : '0;
      result.slope4     <= (order == ORDER_RK4) ? 32'(k4) : '0;
      result.last       <= last_r;
      result.overflow   <= ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_done_while_waiting: assert property (@(posedge clk) disable iff (rst)
    mstat.done |-> (state == S_XW || state == S_M1 || state == S_M2 || state == S_M3))
    else $error("multiplier result arrived outside a wait state");
`endif

endmodule

### design/runge_kutta_ode_step.sv
`timescale 1ns / 1ps
// Fixed-point Runge-Kutta stepper for y' = y*x*x - y, signed Q16.16 by default.
// Configure start_x, start_y, step_size, step_count and order through the
// write port (cfg_we, cfg_index, cfg_data) while the block is idle.
// Each beat on item produces one beat on result: step index, x at the end of
// the step, new y, slopes k1..k4 (k3 and k4 read zero in Heun mode), a last
// flag at the end of a run and a saturation flag. restart, or any beat after
// the last step, reloads y from start_y and restarts the index at 1.
// A front stage numbers the steps and pushes them into a two-entry queue;
// the back stage runs the slope evaluations on one shared multiplier.
// Fourth order needs 13 products plus a reciprocal divide by six; Heun
// needs 7 products. Items are worked one at a time; the queue takes up
// to two more while one is in the back stage.
// The result sits in an output register; a stalled receiver holds it and
// the back stage waits, then the queue fills and item.ready drops.
// Synchronous reset loads the register defaults and starts a fresh run.
module runge_kutta_ode_step #(
  parameter int WORD_BITS  = rkos_pkg::RKOS_WORD_BITS,
  parameter int FRAC_BITS  = rkos_pkg::RKOS_FRAC_BITS,
  parameter int COUNT_BITS = rkos_pkg::RKOS_COUNT_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rkos_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [rkos_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  rkos_in_if.sink                             item,
  rkos_out_if.source                          result
);
  import rkos_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int EW = (W > 32) ? W : 32;
  localparam int MAG_BITS = (W > COUNT_BITS) ? W : COUNT_BITS;

  logic [31:0] start_x_r, start_y_r, step_size_r;
  logic [15:0] step_count_r;
  logic        order_r;

  logic signed [W-1:0] start_x_w, start_y_w, step_size_w;

  logic                  push_valid, push_ready;
  rkos_flags_t           push_flags;
  logic [COUNT_BITS-1:0] push_index;
  logic                  q_valid, q_pop;
  rkos_flags_t           q_flags;
  logic [COUNT_BITS-1:0] q_index;

  rkos_mul_ctl_t       mctl;
  rkos_mul_stat_t      mstat;
  logic [MAG_BITS-1:0] m_a, m_b;
  logic signed [W-1:0] m_res;

  // sign-extend, then clamp into a narrower word
  function automatic logic signed [W-1:0] to_word(logic [31:0] r);
    logic signed [EW-1:0] s;
    logic signed [EW-1:0] hi;
    logic signed [EW-1:0] lo;
    s  = EW'($signed(r));
    hi = $signed(EW'({1'b0, {(W-1){1'b1}}}));
    lo = -hi - EW'(1);
    if (s > hi) return W'(hi);
    if (s < lo) return W'(lo);
    return W'(s);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x_r    <= START_X_RST;
      start_y_r    <= START_Y_RST;
      step_size_r  <= STEP_SIZE_RST;
      step_count_r <= STEP_COUNT_RST;
      order_r      <= ORDER_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_X:    start_x_r    <= cfg_data;
        CFG_START_Y:    start_y_r    <= cfg_data;
        CFG_STEP_SIZE:  step_size_r  <= cfg_data;
        CFG_STEP_COUNT: step_count_r <= cfg_data[15:0];
        CFG_ORDER:      order_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign start_x_w   = to_word(start_x_r);
  assign start_y_w   = to_word(start_y_r);
  assign step_size_w = to_word(step_size_r);

  rkos_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .step_count (step_count_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_flags (push_flags),
    .push_index (push_index)
  );

  rkos_fifo #(.DATA_BITS(COUNT_BITS + 2)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  ({push_flags, push_index}),
    .rd_valid (q_valid),
    .rd_ready (q_pop),
    .rd_data  ({q_flags, q_index})
  );

  rkos_mul #(
    .WORD_BITS (W),
    .FRAC_BITS (FRAC_BITS),
    .MAG_BITS  (MAG_BITS)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .ctl   (mctl),
    .a_mag (m_a),
    .b_mag (m_b),
    .stat  (mstat),
    .res   (m_res)
  );

  rkos_back #(
    .WORD_BITS  (W),
    .COUNT_BITS (COUNT_BITS),
    .MAG_BITS   (MAG_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .start_x   (start_x_w),
    .start_y   (start_y_w),
    .step_size (step_size_w),
    .order     (order_r),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_flags   (q_flags),
    .q_index   (q_index),
    .mctl      (mctl),
    .m_a       (m_a),
    .m_b       (m_b),
    .mstat     (mstat),
    .m_res     (m_res),
    .result    (result)
  );

endmodule
